[design/mf3_pkg.sv]
package mf3_pkg;

    localparam int CH_W           = 8;
    localparam int NUM_CH         = 3;
    localparam int PIX_W          = NUM_CH * CH_W;
    localparam int WIN_N          = 3;
    localparam int WIN_SZ         = WIN_N * WIN_N;
    localparam int CFG_W          = 13;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 3;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int LANE_STAGES    = 3;
    localparam int FIFO_DEPTH     = 16;

    localparam logic [CFG_W-1:0] CFG_RST_SIZE = 13'd4096;

    // pixel packed as red (high byte), green, blue (low byte)
    typedef logic [PIX_W-1:0] t_pix;

    // one channel of a 3x3 window, index row*3+col
    typedef logic [WIN_SZ-1:0][CH_W-1:0] t_win9;

    typedef struct packed {
        logic emit_a;     // window result for column c-1
        logic emit_b;     // right-edge result for the last column
        logic frame_end;
    } t_emit_ctl;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

endpackage

[design/mf3_ram.sv]
module mf3_ram
    import mf3_pkg::*;
#(
    parameter int WIDTH = PIX_W,
    parameter int DEPTH = DEF_MAX_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/mf3_lane.sv]
module mf3_lane
    import mf3_pkg::*;
(
    input  logic            i_clk,
    input  t_win9           i_win,
    output logic [CH_W-1:0] o_median
);

    typedef logic [CH_W-1:0] t_ch;

    function automatic t_ch f_min(input t_ch a, input t_ch b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_ch f_max(input t_ch a, input t_ch b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_ch f_med3(input t_ch a, input t_ch b, input t_ch c);
        return f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

    t_ch n_lo [WIN_N];
    t_ch n_md [WIN_N];
    t_ch n_hi [WIN_N];
    t_ch r_lo [WIN_N];
    t_ch r_md [WIN_N];
    t_ch r_hi [WIN_N];
    t_ch n_max_lo, n_med_md, n_min_hi;
    t_ch r_max_lo, r_med_md, r_min_hi;
    t_ch n_median, r_median;

    // stage A: sort each row
    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            n_lo[i] = f_min(f_min(i_win[i*WIN_N], i_win[i*WIN_N+1]), i_win[i*WIN_N+2]);
            n_hi[i] = f_max(f_max(i_win[i*WIN_N], i_win[i*WIN_N+1]), i_win[i*WIN_N+2]);
            n_md[i] = f_med3(i_win[i*WIN_N], i_win[i*WIN_N+1], i_win[i*WIN_N+2]);
        end
    end

    // stage B: max of lows, median of mids, min of highs
    always_comb begin
        n_max_lo = f_max(f_max(r_lo[0], r_lo[1]), r_lo[2]);
        n_med_md = f_med3(r_md[0], r_md[1], r_md[2]);
        n_min_hi = f_min(f_min(r_hi[0], r_hi[1]), r_hi[2]);
    end

    // stage C
    assign n_median = f_med3(r_max_lo, r_med_md, r_min_hi);

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_md     <= n_md;
        r_hi     <= n_hi;
        r_max_lo <= n_max_lo;
        r_med_md <= n_med_md;
        r_min_hi <= n_min_hi;
        r_median <= n_median;
    end

    assign o_median = r_median;

endmodule

[design/mf3_merge.sv]
module mf3_merge
    import mf3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_emit_ctl        i_ctl,
    input  t_pix             i_pix_a,
    input  t_pix             i_pix_b,
    input  logic             i_tready,
    output logic             o_tvalid,
    output logic [PIX_W-1:0] o_tdata,   // median_red, median_green, median_blue
    output logic             o_tlast,
    output logic             o_tuser    // frame_end
);

    localparam int AW = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic frame_end;
        logic run_end;
        t_pix pix;
    } t_out_item;

    t_out_item       r_mem [FIFO_DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [AW:0]     r_count, n_count;
    logic            both;
    logic [1:0]      push_n;
    logic            pop;
    t_out_item       first_item, second_item, head;

    always_comb begin
        both   = i_ctl.emit_a && i_ctl.emit_b;
        push_n = i_push ? ({1'b0, i_ctl.emit_a} + {1'b0, i_ctl.emit_b}) : 2'd0;

        first_item.pix       = i_ctl.emit_a ? i_pix_a : i_pix_b;
        first_item.run_end   = !both;
        first_item.frame_end = i_ctl.frame_end && !i_ctl.emit_a;

        second_item.pix       = i_pix_b;
        second_item.run_end   = 1'b1;
        second_item.frame_end = i_ctl.frame_end;

        pop      = o_tvalid && i_tready;
        n_wr_ptr = r_wr_ptr + AW'(push_n);
        n_rd_ptr = r_rd_ptr + AW'(pop);
        n_count  = r_count + (AW+1)'(push_n) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= first_item;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr_ptr + AW'(1)] <= second_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign head     = r_mem[r_rd_ptr];
    assign o_tvalid = (r_count != '0);
    assign o_tdata  = {head.pix[CH_W-1:0], head.pix[2*CH_W-1:CH_W], head.pix[PIX_W-1:2*CH_W]};
    assign o_tlast  = head.run_end;
    assign o_tuser  = head.frame_end;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ({1'b0, r_count} + push_n) <= FIFO_DEPTH)
        else $error("result queue overflow");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && o_tuser |-> o_tlast)
        else $error("frame end not on last result of its request");

    a_frame_end_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && i_ctl.frame_end |-> i_ctl.emit_b)
        else $error("frame end without right-edge result");

endmodule

[design/median_filter_3x3_rgb_top.sv]
// A request passes the stage-1, window and lane registers and the result queue before
// its first result shows; a right-edge second result follows it from the queue.
// Throughput: one pixel per cycle in, one result per cycle out while result credit and the
// receiver allow, set by the read-first line-store port and pipelined per-channel median lanes.
// Reset (synchronous, active low) clears position, pipeline and queue state and sets
// width and height to 4096; line stores are not cleared and need no clearing pass.
module median_filter_3x3_rgb_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [PIX_W-1:0]  i_s_axis_tdata,   // red, green, blue
    input  logic              i_s_axis_tuser,   // func
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [PIX_W-1:0]  o_m_axis_tdata,   // median_red, median_green, median_blue
    output logic              o_m_axis_tlast,   // run_end
    output logic              o_m_axis_tuser,   // frame_end
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT + 1);
    localparam int USED_W = $clog2(FIFO_DEPTH + 1);

    function automatic logic [CFG_W:0] f_clamp(input logic [CFG_W-1:0] v,
                                              input logic [CFG_W:0]   lim);
        if (v == '0) begin
            return (CFG_W+1)'(1);
        end else if ({1'b0, v} > lim) begin
            return lim;
        end
        return {1'b0, v};
    endfunction

    // configuration
    logic [CFG_W-1:0] r_width_raw, r_height_raw;
    logic [CW-1:0]    r_w_last;
    logic [RW-1:0]    r_h;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    // stage 0
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic             in_acc, col_last, pad_row, row_le1;
    t_pix             in_pix, sample;
    t_emit_ctl        in_ctl;
    logic [1:0]       in_nres;

    // stage 1
    logic             r_s1_valid;
    logic [CW-1:0]    r_s1_addr;
    t_pix             r_s1_sample;
    logic             r_s1_c0, r_s1_le1, r_s1_fwd;
    t_emit_ctl        r_s1_ctl;
    t_pix             r_fwd_up, r_fwd_mid;
    t_pix             ram_up_q, ram_mid_q, up_eff, mid_eff;

    // window and lanes
    t_pix             r_win [WIN_SZ];
    t_pix             n_win [WIN_SZ];
    logic             r_s2_valid;
    t_emit_ctl        r_s2_ctl;
    logic             r_pv   [LANE_STAGES];
    t_emit_ctl        r_pctl [LANE_STAGES];
    logic [NUM_CH-1:0][CH_W-1:0] med_main, med_edge;

    // result credit
    logic [USED_W-1:0] r_used;
    logic              pop;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = {{(APB_DW-CFG_W){1'b0}}, r_width_raw};
            REG_FRAME_HEIGHT: prdata = {{(APB_DW-CFG_W){1'b0}}, r_height_raw};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_raw  <= CFG_RST_SIZE;
            r_height_raw <= CFG_RST_SIZE;
            r_w_last     <= CW'(f_clamp(CFG_RST_SIZE, (CFG_W+1)'(MAX_WIDTH)) - (CFG_W+1)'(1));
            r_h          <= RW'(f_clamp(CFG_RST_SIZE, (CFG_W+1)'(MAX_HEIGHT)));
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH: begin
                    r_width_raw <= pwdata[CFG_W-1:0];
                    r_w_last    <= CW'(f_clamp(pwdata[CFG_W-1:0], (CFG_W+1)'(MAX_WIDTH))
                                       - (CFG_W+1)'(1));
                end
                REG_FRAME_HEIGHT: begin
                    r_height_raw <= pwdata[CFG_W-1:0];
                    r_h          <= RW'(f_clamp(pwdata[CFG_W-1:0], (CFG_W+1)'(MAX_HEIGHT)));
                end
            endcase
        end
    end

    // ---------------- stage 0: position, sample, line-store read ----------------
    assign o_s_axis_tready = (r_used <= USED_W'(FIFO_DEPTH - 2));
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        col_last = (r_col == r_w_last);
        pad_row  = (r_row == r_h);
        row_le1  = (r_row == '0) || (r_row == RW'(1));
        in_pix   = {i_s_axis_tdata[CH_W-1:0], i_s_axis_tdata[2*CH_W-1:CH_W],
                    i_s_axis_tdata[PIX_W-1:2*CH_W]};
        sample   = (!i_s_axis_tuser && !pad_row) ? in_pix : '0;

        in_ctl.emit_a    = (r_row != '0) && (r_col != '0);
        in_ctl.emit_b    = (r_row != '0) && col_last;
        in_ctl.frame_end = pad_row && col_last;
        in_nres          = {1'b0, in_ctl.emit_a} + {1'b0, in_ctl.emit_b};

        n_col = col_last ? '0 : r_col + CW'(1);
        if (col_last) begin
            n_row = pad_row ? '0 : r_row + RW'(1);
        end else begin
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (mid_eff),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (ram_up_q)
    );

    mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_middle (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_sample),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (ram_mid_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr   <= r_col;
            r_s1_sample <= sample;
            r_s1_c0     <= (r_col == '0);
            r_s1_le1    <= row_le1;
            r_s1_ctl    <= in_ctl;
            // same address written back this edge: ram returns stale data
            r_s1_fwd    <= r_s1_valid && (r_s1_addr == r_col);
            r_fwd_up    <= mid_eff;
            r_fwd_mid   <= r_s1_sample;
        end
    end

    // ---------------- stage 1: window shift ----------------
    always_comb begin
        mid_eff = r_s1_fwd ? r_fwd_mid : ram_mid_q;
        up_eff  = r_s1_le1 ? '0 : (r_s1_fwd ? r_fwd_up : ram_up_q);
        for (int i = 0; i < WIN_N; i++) begin
            n_win[i*WIN_N]   = r_s1_c0 ? '0 : r_win[i*WIN_N+1];
            n_win[i*WIN_N+1] = r_s1_c0 ? '0 : r_win[i*WIN_N+2];
        end
        n_win[WIN_N-1]        = up_eff;
        n_win[2*WIN_N-1]      = mid_eff;
        n_win[WIN_N*WIN_N-1]  = r_s1_sample;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win    <= n_win;
            r_s2_ctl <= r_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            for (int k = 0; k < LANE_STAGES; k++) begin
                r_pv[k] <= 1'b0;
            end
        end else begin
            r_s2_valid <= r_s1_valid;
            r_pv[0]    <= r_s2_valid;
            for (int k = 1; k < LANE_STAGES; k++) begin
                r_pv[k] <= r_pv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pctl[0] <= r_s2_ctl;
        for (int k = 1; k < LANE_STAGES; k++) begin
            r_pctl[k] <= r_pctl[k-1];
        end
    end

    // ---------------- median lanes: one per channel, main and right-edge window ----------------
    for (genvar b = 0; b < NUM_CH; b++) begin : g_lane
        t_win9 win_main, win_edge;

        always_comb begin
            for (int i = 0; i < WIN_SZ; i++) begin
                win_main[i] = r_win[i][b*CH_W +: CH_W];
            end
            for (int i = 0; i < WIN_N; i++) begin
                win_edge[i*WIN_N]   = r_win[i*WIN_N+1][b*CH_W +: CH_W];
                win_edge[i*WIN_N+1] = r_win[i*WIN_N+2][b*CH_W +: CH_W];
                win_edge[i*WIN_N+2] = '0;
            end
        end

        mf3_lane u_main (
            .i_clk    (i_clk),
            .i_win    (win_main),
            .o_median (med_main[b])
        );

        mf3_lane u_edge (
            .i_clk    (i_clk),
            .i_win    (win_edge),
            .o_median (med_edge[b])
        );
    end

    mf3_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_pv[LANE_STAGES-1]),
        .i_ctl    (r_pctl[LANE_STAGES-1]),
        .i_pix_a  (t_pix'(med_main)),
        .i_pix_b  (t_pix'(med_edge)),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast),
        .o_tuser  (o_m_axis_tuser)
    );

    // ---------------- result credit: queued plus in flight ----------------
    assign pop = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= r_used + (in_acc ? USED_W'(in_nres) : USED_W'(0)) - USED_W'(pop);
        end
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(FIFO_DEPTH))
        else $error("result credit exceeds queue depth");

    a_fwd_single_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_fwd |-> r_w_last == '0)
        else $error("line-store bypass used with width above one");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_used != '0)
        else $error("result presented with no credit held");

endmodule

[test/tb_median_filter_3x3_rgb_top.sv]
`timescale 1ns / 100ps

module tb_median_filter_3x3_rgb_top;
    import mf3_pkg::*;

    typedef struct packed {
        bit          func;
        bit [23:0]   pix;     // blue, green, red (red in low byte)
    } t_pixel;

    typedef struct packed {
        bit          frame_end;
        bit          run_end;
        bit [23:0]   pix;
    } t_median;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [PIX_W-1:0]  i_s_axis_tdata;
    logic              i_s_axis_tuser;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [PIX_W-1:0]  o_m_axis_tdata;
    logic              o_m_axis_tlast;
    logic              o_m_axis_tuser;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    median_filter_3x3_rgb_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    t_pixel    pixel_q[$];
    t_median   median_q[$];
    t_pixel    cur_px;
    int        err_cnt = 0;
    bit        src_idle_en = 1'b0;
    bit        sink_idle_en = 1'b0;
    bit        sink_hold_req = 1'b0;
    int        src_gap;
    int        sink_gap;
    int        hold_cnt;

    // predictor state
    bit [23:0]      upper_line[DEF_MAX_WIDTH];
    bit [23:0]      middle_line[DEF_MAX_WIDTH];
    bit [23:0]      win_pix[9];
    int             row_pos = 0;
    int             col_pos = 0;
    bit [CFG_W-1:0] cfg_width = CFG_RST_SIZE;
    bit [CFG_W-1:0] cfg_height = CFG_RST_SIZE;

    function automatic int eff_size(bit [CFG_W-1:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic t_median window_median(bit [23:0] wv[9]);
        t_median   m;
        bit [7:0]  v[9];
        bit [7:0]  x;
        int        i, j, k;
        m = '0;
        for (k = 0; k < 3; k++) begin
            for (i = 0; i < 9; i++) v[i] = wv[i][8*k +: 8];
            for (i = 1; i < 9; i++) begin
                x = v[i];
                j = i - 1;
                while (j >= 0 && v[j] > x) begin
                    v[j+1] = v[j];
                    j--;
                end
                v[j+1] = x;
            end
            m.pix[8*k +: 8] = v[4];
        end
        return m;
    endfunction

    function automatic void filter_pixel(t_pixel it);
        int        w, h, c, r, n, i;
        bit [23:0] sample, up, mid;
        bit [23:0] rim_win[9];
        t_median   res[2];
        w = eff_size(cfg_width, DEF_MAX_WIDTH);
        h = eff_size(cfg_height, DEF_MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        n = 0;
        if (c >= w) c = 0;
        if (r > h) r = 0;
        sample = (!it.func && r < h) ? it.pix : 24'h0;
        up = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = sample;
        if (r <= 1) up = 24'h0;
        for (i = 0; i < 3; i++) begin
            win_pix[i*3]   = (c == 0) ? 24'h0 : win_pix[i*3+1];
            win_pix[i*3+1] = (c == 0) ? 24'h0 : win_pix[i*3+2];
        end
        win_pix[2] = up;
        win_pix[5] = mid;
        win_pix[8] = sample;
        if (r >= 1) begin
            if (c >= 1) begin
                res[n] = window_median(win_pix);
                n++;
            end
            if (c == w - 1) begin
                for (i = 0; i < 3; i++) begin
                    rim_win[i*3]   = win_pix[i*3+1];
                    rim_win[i*3+1] = win_pix[i*3+2];
                    rim_win[i*3+2] = 24'h0;
                end
                res[n] = window_median(rim_win);
                n++;
            end
            if (n > 0) begin
                res[n-1].run_end = 1'b1;
                if (r == h && c == w - 1) res[n-1].frame_end = 1'b1;
            end
            for (i = 0; i < n; i++) median_q.push_back(res[i]);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r > h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    // source side
    always @(posedge i_clk) begin : src_proc
        bit nv;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            nv = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                filter_pixel(cur_px);
                nv = 1'b0;
            end
            if (!nv && pixel_q.size() != 0) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (src_idle_en && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 7);
                end else begin
                    cur_px = pixel_q.pop_front();
                    i_s_axis_tdata <= cur_px.pix;
                    i_s_axis_tuser <= cur_px.func;
                    nv = 1'b1;
                end
            end
            i_s_axis_tvalid <= nv;
        end
    end

    // sink side: ready pattern and result check
    always @(posedge i_clk) begin : sink_proc
        bit      nr;
        t_median exp_res;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_gap = 0;
            hold_cnt = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (median_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("unexpected result: rgb %h/%h/%h last %b user %b",
                                 o_m_axis_tdata[7:0], o_m_axis_tdata[15:8],
                                 o_m_axis_tdata[23:16], o_m_axis_tlast, o_m_axis_tuser);
                    err_cnt++;
                end else begin
                    exp_res = median_q.pop_front();
                    if (o_m_axis_tdata[7:0] !== exp_res.pix[7:0] ||
                        o_m_axis_tdata[15:8] !== exp_res.pix[15:8] ||
                        o_m_axis_tdata[23:16] !== exp_res.pix[23:16] ||
                        o_m_axis_tlast !== exp_res.run_end ||
                        o_m_axis_tuser !== exp_res.frame_end) begin
                        if (err_cnt < 10)
                            $display({"mismatch: exp rgb %h/%h/%h last %b user %b, ",
                                      "got rgb %h/%h/%h last %b user %b"},
                                     exp_res.pix[7:0], exp_res.pix[15:8],
                                     exp_res.pix[23:16],
                                     exp_res.run_end, exp_res.frame_end,
                                     o_m_axis_tdata[7:0], o_m_axis_tdata[15:8],
                                     o_m_axis_tdata[23:16], o_m_axis_tlast,
                                     o_m_axis_tuser);
                        err_cnt++;
                    end
                end
            end
            if (sink_hold_req) begin
                hold_cnt = 300;
                sink_hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                nr = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                nr = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 7);
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
            i_m_axis_tready <= nr;
        end
    end

    task automatic cfg_write(t_reg_idx idx, bit [CFG_W-1:0] val);
        int i;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FRAME_WIDTH) cfg_width = val;
        else cfg_height = val;
        row_pos = 0;
        col_pos = 0;
        for (i = 0; i < 9; i++) win_pix[i] = 24'h0;
    endtask

    task automatic set_size(int wv, int hv);
        if ($urandom_range(0, 1)) begin
            cfg_write(REG_FRAME_WIDTH, CFG_W'(wv));
            cfg_write(REG_FRAME_HEIGHT, CFG_W'(hv));
        end else begin
            cfg_write(REG_FRAME_HEIGHT, CFG_W'(hv));
            cfg_write(REG_FRAME_WIDTH, CFG_W'(wv));
        end
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || i_s_axis_tvalid || median_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic bit [23:0] rand_pix();
        bit [23:0] p;
        case ($urandom_range(0, 9))
            0: p = 24'h000000;
            1: p = 24'hffffff;
            2: p = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                    {8{$urandom_range(0, 1) == 1}}};
            default: p = 24'($urandom);
        endcase
        return p;
    endfunction

    // n requests in raster order over w x h frames, each followed by its pad row
    task automatic push_frames(int w, int h, int n);
        int     k, r;
        t_pixel px;
        for (k = 0; k < n; k++) begin
            r = (k / w) % (h + 1);
            if (r < h) px.func = ($urandom_range(0, 19) == 0);
            else px.func = ($urandom_range(0, 9) != 0);
            px.pix = rand_pix();
            pixel_q.push_back(px);
        end
    endtask

    task automatic push_px(bit func, bit [23:0] pix);
        t_pixel px;
        px.func = func;
        px.pix = pix;
        pixel_q.push_back(px);
    endtask

    initial begin
        int wv, hv, n, rand_cnt;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        rand_cnt = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default 4096 wide: first row gives nothing
        push_px(1'b0, 24'hffffff);
        push_px(1'b0, 24'h000000);
        push_px(1'b1, 24'h123456);
        push_px(1'b0, 24'ha5a5a5);
        push_px(1'b0, 24'h5a5a5a);
        wait_idle();

        // zero sizes act as 1x1, pixel in pad row, frame wrap
        set_size(0, 0);
        push_px(1'b0, 24'hffffff);
        push_px(1'b1, 24'h000000);
        push_px(1'b0, 24'h00ff00);
        push_px(1'b0, 24'hffffff);
        wait_idle();

        // 3x2 with pad inside the image and a pixel in the pad row
        set_size(3, 2);
        push_px(1'b0, 24'hffffff);
        push_px(1'b0, 24'h000000);
        push_px(1'b1, 24'hffffff);
        push_px(1'b0, 24'h808080);
        push_px(1'b0, 24'hffffff);
        push_px(1'b0, 24'h030201);
        push_px(1'b1, 24'h000000);
        push_px(1'b0, 24'hffffff);
        push_px(1'b1, 24'h7f7f7f);
        push_px(1'b0, 24'hfefefe);
        push_px(1'b0, 24'h010101);
        push_px(1'b0, 24'hff00ff);
        wait_idle();

        // oversize width clamps to the maximum, start of the first row
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        set_size(8191, 1);
        push_frames(DEF_MAX_WIDTH, 1, 64);
        wait_idle();

        // oversize height, partial frame
        set_size(2, 8191);
        push_frames(2, DEF_MAX_HEIGHT, 40);
        wait_idle();

        // long receiver hold while the sender keeps offering
        src_idle_en = 1'b0;
        set_size(8, 6);
        push_frames(8, 6, 2 * 8 * 7);
        sink_hold_req = 1'b1;
        wait_idle();

        while (rand_cnt < 450) begin
            wv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            hv = $urandom_range(0, 6);
            set_size(wv, hv);
            src_idle_en = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            n = eff_size(CFG_W'(wv), DEF_MAX_WIDTH) * (eff_size(CFG_W'(hv), DEF_MAX_HEIGHT) + 1)
                * $urandom_range(1, 3);
            if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
            push_frames(eff_size(CFG_W'(wv), DEF_MAX_WIDTH),
                        eff_size(CFG_W'(hv), DEF_MAX_HEIGHT), n);
            rand_cnt += n;
            wait_idle();
        end

        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        set_size(5, 4);
        push_frames(5, 4, 2 * 5 * 5);
        wait_idle();

        if (err_cnt == 0 && median_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
